>>> sv/bwlp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwlp_pkg
// Shared types, constants and the control program of the fourth-order
// Butterworth low-pass unit.
// ---------------------------------------------------------------------------
package bwlp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 24;
    localparam int STATE_WIDTH_DEF  = 32;

    // Integer bits of a coefficient; the rest are fraction bits.
    localparam int COEF_INT_BITS = 4;

    localparam int COEFS_PER_SEC = 3;
    localparam int NUM_SECTIONS  = 2;
    localparam int NUM_COEFS     = COEFS_PER_SEC * NUM_SECTIONS;
    localparam int COEF_IDX_W    = $clog2(NUM_COEFS);

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_S1_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_S1_FB1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_S1_FB2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_S2_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_S2_FB1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_S2_FB2  = 3'd6;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
    localparam logic [PC_W-1:0] PC_OUT   = 4'd13;
    localparam logic [PC_W-1:0] PC_PASS  = 4'd14;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_BYPASS,
        COND_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        COEF_GAIN,
        COEF_FB1,
        COEF_FB2
    } coef_sel_t;

    typedef enum logic [1:0] {
        OPD_SRC,
        OPD_W1,
        OPD_W2
    } opd_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_FILT,
        OUT_PASS
    } out_op_t;

    typedef struct packed {
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            end_step;
        logic            sec;
        logic            mul_en;
        coef_sel_t       coef_sel;
        opd_sel_t        opd_sel;
        acc_op_t         acc_op;
        logic            round_en;
        logic            update_en;
        out_op_t         out_op;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic enable;
        logic out_busy;
    } stat_t;

    localparam ucode_t UC_NOP = '{
        cond:      COND_NEVER,
        target:    PC_WAIT,
        end_step:  1'b0,
        sec:       1'b0,
        mul_en:    1'b0,
        coef_sel:  COEF_GAIN,
        opd_sel:   OPD_SRC,
        acc_op:    ACC_HOLD,
        round_en:  1'b0,
        update_en: 1'b0,
        out_op:    OUT_NONE
    };

    // Control store. Each section runs the same six steps: three multiplies
    // into the shared accumulator, a rounding step and a state update.
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t u;
        u = UC_NOP;
        case (pc)
            4'd0:
            begin
                u.cond   = COND_NO_INPUT;
                u.target = PC_WAIT;
            end
            4'd1, 4'd7:
            begin
                if (pc == PC_CHECK)
                begin
                    u.cond   = COND_BYPASS;
                    u.target = PC_PASS;
                end
                u.sec      = (pc == 4'd7);
                u.mul_en   = 1'b1;
                u.coef_sel = COEF_GAIN;
                u.opd_sel  = OPD_SRC;
            end
            4'd2, 4'd8:
            begin
                u.sec      = (pc == 4'd8);
                u.mul_en   = 1'b1;
                u.coef_sel = COEF_FB1;
                u.opd_sel  = OPD_W1;
                u.acc_op   = ACC_LOAD;
            end
            4'd3, 4'd9:
            begin
                u.sec      = (pc == 4'd9);
                u.mul_en   = 1'b1;
                u.coef_sel = COEF_FB2;
                u.opd_sel  = OPD_W2;
                u.acc_op   = ACC_SUB;
            end
            4'd4, 4'd10:
            begin
                u.sec    = (pc == 4'd10);
                u.acc_op = ACC_SUB;
            end
            4'd5, 4'd11:
            begin
                u.sec      = (pc == 4'd11);
                u.round_en = 1'b1;
            end
            4'd6, 4'd12:
            begin
                u.sec       = (pc == 4'd12);
                u.update_en = 1'b1;
            end
            4'd13:
            begin
                u.cond     = COND_OUT_BUSY;
                u.target   = PC_OUT;
                u.end_step = 1'b1;
                u.out_op   = OUT_FILT;
            end
            4'd14:
            begin
                u.cond     = COND_OUT_BUSY;
                u.target   = PC_PASS;
                u.end_step = 1'b1;
                u.out_op   = OUT_PASS;
            end
            default:
            begin
                u.end_step = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

>>> sv/bwlp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwlp_if
// Handshake channels of the low-pass unit: sample input, sample output and
// the register write port.
// ---------------------------------------------------------------------------
interface bwlp_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface bwlp_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface bwlp_cfg_if #(parameter int IDX_WIDTH = 3, parameter int DATA_WIDTH = 24);
    logic                  valid;
    logic                  ready;
    logic [IDX_WIDTH-1:0]  index;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/butterworth_lowpass_4th_order_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// butterworth_lowpass_4th_order_unit
// Fourth-order low-pass filter from two cascaded biquad sections, run by a
// small microprogram over one shared multiplier.
// ---------------------------------------------------------------------------
// Usage: samples enter on din and filtered samples leave on dout, one output
// word for every input word, in order. Coefficients and the enable bit are
// written on cfg, which is always ready and should only be used while the
// unit is idle.
// With the filter enabled, each section spends six steps of the program on
// three multiplies through the single multiplier, the accumulation,
// rounding and the state update, and one more step forms the output. With
// the filter disabled, the program branches from its check step straight
// to the pass-through step, which loads the output register.
// A new word is accepted only once the program has returned to its wait
// step, so the unit does not take a word while the last one is still in
// the program.
// Reset clears the section state, the configuration registers (filter
// disabled, all coefficients zero) and the output valid flag.
// When dout stalls, a finished word is held in the output register; the next
// word is still accepted and computed, and the program waits at its output
// step until the register is free.
// ---------------------------------------------------------------------------
module butterworth_lowpass_4th_order_unit #(
    parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bwlp_pkg::COEF_WIDTH_DEF,
    parameter int STATE_WIDTH  = bwlp_pkg::STATE_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    bwlp_in_if.sink   din,
    bwlp_out_if.source dout,
    bwlp_cfg_if.sink  cfg
);
    import bwlp_pkg::*;

    logic                         enable_reg;
    logic signed [COEF_WIDTH-1:0] coef_reg [NUM_COEFS];
    ucode_t                       ctl;
    stat_t                        stat;
    logic                         in_ready;
    logic                         in_fire;
    logic                         out_busy;

    assign cfg.ready = 1'b1;
    assign din.ready = in_ready;
    assign in_fire   = din.valid && in_ready;

    assign stat.in_valid = din.valid;
    assign stat.enable   = enable_reg;
    assign stat.out_busy = out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            for (int i = 0; i < NUM_COEFS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_ENABLE)
                enable_reg <= cfg.data[0];
            else if (cfg.index inside {[REG_S1_GAIN:REG_S2_FB2]})
                coef_reg[COEF_IDX_W'(cfg.index - REG_S1_GAIN)] <= cfg.data;
        end
    end

    bwlp_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .ctl      (ctl),
        .in_ready (in_ready)
    );

    bwlp_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_fire    (in_fire),
        .sample_in  (din.sample_in),
        .coef       (coef_reg),
        .out_ready  (dout.ready),
        .out_valid  (dout.valid),
        .sample_out (dout.sample_out),
        .out_busy   (out_busy)
    );

endmodule

>>> sv/bwlp_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwlp_sequencer
// Step counter over the control store, with conditional jumps for input
// wait, bypass and output backpressure.
// ---------------------------------------------------------------------------
module bwlp_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  bwlp_pkg::stat_t stat,
    output bwlp_pkg::ucode_t ctl,
    output logic            in_ready
);
    import bwlp_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign ctl      = ucode(pc_reg);
    assign in_ready = (ctl.cond == COND_NO_INPUT);

    always_comb
    begin
        case (ctl.cond)
            COND_NO_INPUT: taken = !stat.in_valid;
            COND_BYPASS:   taken = !stat.enable;
            COND_OUT_BUSY: taken = stat.out_busy;
            default:       taken = 1'b0;
        endcase
        if (taken)
            pc_next = ctl.target;
        else if (ctl.end_step)
            pc_next = PC_WAIT;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_WAIT;
        else
            pc_reg <= pc_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && stat.in_valid |=> pc_reg == PC_CHECK)
        else $error("accepted word did not start the program");

    a_bypass_jump: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cond == COND_BYPASS && !stat.enable |=> pc_reg == PC_PASS)
        else $error("disabled filter did not branch to pass-through");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_op != OUT_NONE && stat.out_busy |=> $stable(pc_reg))
        else $error("output step left while output register was full");

    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_op != OUT_NONE && !stat.out_busy |=> pc_reg == PC_WAIT)
        else $error("program did not return to wait after output");

endmodule

>>> sv/bwlp_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bwlp_datapath
// Shared multiplier, accumulator, rounding and saturation, section state
// and the output register, all driven by the control word.
// ---------------------------------------------------------------------------
module bwlp_datapath #(
    parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bwlp_pkg::COEF_WIDTH_DEF,
    parameter int STATE_WIDTH  = bwlp_pkg::STATE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bwlp_pkg::ucode_t               ctl,
    input  logic                           in_fire,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic signed [COEF_WIDTH-1:0]   coef [bwlp_pkg::NUM_COEFS],
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           out_busy
);
    import bwlp_pkg::*;

    localparam int COEF_FRAC  = COEF_WIDTH - COEF_INT_BITS;
    localparam int STATE_FRAC = STATE_WIDTH / 2;
    localparam int XIN_W      = SAMPLE_WIDTH + STATE_FRAC;
    localparam int DATA_W     = (STATE_WIDTH > XIN_W) ? STATE_WIDTH : XIN_W;
    localparam int PROD_W     = COEF_WIDTH + DATA_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int YS_W       = STATE_WIDTH + 3;
    localparam int OS_W       = STATE_WIDTH + 1;

    localparam logic signed [ACC_W:0]  RND_HALF = (ACC_W + 1)'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [OS_W-1:0] OUT_HALF = OS_W'(1) <<< (STATE_FRAC - 1);
    localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH - 1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SM_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SM_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [STATE_WIDTH-1:0]  w_reg;
    logic signed [STATE_WIDTH-1:0]  w_next;
    logic signed [STATE_WIDTH-1:0]  y_reg;
    logic signed [STATE_WIDTH-1:0]  y_next;
    logic signed [STATE_WIDTH-1:0]  w1_reg [NUM_SECTIONS];
    logic signed [STATE_WIDTH-1:0]  w2_reg [NUM_SECTIONS];
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_next;

    logic [COEF_IDX_W-1:0]        cidx;
    logic signed [COEF_WIDTH-1:0] coef_val;
    logic signed [DATA_W-1:0]     x_ext;
    logic signed [DATA_W-1:0]     opd;
    logic signed [ACC_W:0]        rnd_sum;
    logic signed [ACC_W:0]        rnd_shift;
    logic signed [YS_W-1:0]       y_sum;
    logic signed [OS_W-1:0]       o_sum;
    logic signed [OS_W-1:0]       o_shift;
    logic                         out_write;

    assign x_ext    = DATA_W'(x_reg) <<< STATE_FRAC;
    assign cidx     = ctl.sec ? (COEF_IDX_W'(COEFS_PER_SEC) + COEF_IDX_W'(ctl.coef_sel))
                              : COEF_IDX_W'(ctl.coef_sel);
    assign coef_val = coef[cidx];

    always_comb
    begin
        case (ctl.opd_sel)
            OPD_SRC: opd = ctl.sec ? DATA_W'(y_reg) : x_ext;
            OPD_W1:  opd = DATA_W'(w1_reg[ctl.sec]);
            OPD_W2:  opd = DATA_W'(w2_reg[ctl.sec]);
            default: opd = '0;
        endcase
        prod_next = PROD_W'(coef_val) * PROD_W'(opd);

        case (ctl.acc_op)
            ACC_LOAD: acc_next = ACC_W'(prod_reg);
            ACC_SUB:  acc_next = acc_reg - ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    // The new state value is rounded half up to the state format and clamped.
    always_comb
    begin
        rnd_sum   = (ACC_W + 1)'(acc_reg) + RND_HALF;
        rnd_shift = rnd_sum >>> COEF_FRAC;
        if (!((&rnd_shift[ACC_W:STATE_WIDTH-1]) || !(|rnd_shift[ACC_W:STATE_WIDTH-1])))
            w_next = rnd_shift[ACC_W] ? ST_MIN : ST_MAX;
        else
            w_next = rnd_shift[STATE_WIDTH-1:0];

        y_sum = YS_W'(w_reg) + (YS_W'(w1_reg[ctl.sec]) <<< 1) + YS_W'(w2_reg[ctl.sec]);
        if (!((&y_sum[YS_W-1:STATE_WIDTH-1]) || !(|y_sum[YS_W-1:STATE_WIDTH-1])))
            y_next = y_sum[YS_W-1] ? ST_MIN : ST_MAX;
        else
            y_next = y_sum[STATE_WIDTH-1:0];

        o_sum   = OS_W'(y_reg) + OUT_HALF;
        o_shift = o_sum >>> STATE_FRAC;
        if (ctl.out_op == OUT_PASS)
            sample_out_next = x_reg;
        else if (!((&o_shift[OS_W-1:SAMPLE_WIDTH-1]) || !(|o_shift[OS_W-1:SAMPLE_WIDTH-1])))
            sample_out_next = o_shift[OS_W-1] ? SM_MIN : SM_MAX;
        else
            sample_out_next = o_shift[SAMPLE_WIDTH-1:0];
    end

    assign out_busy  = out_valid_reg && !out_ready;
    assign out_write = (ctl.out_op != OUT_NONE) && !out_busy;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= sample_in;
        if (ctl.mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (ctl.round_en)
            w_reg <= w_next;
        if (ctl.update_en)
            y_reg <= y_next;
        if (out_write)
            sample_out_reg <= sample_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SECTIONS; i++)
            begin
                w1_reg[i] <= '0;
                w2_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_write)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (ctl.update_en)
            begin
                w2_reg[ctl.sec] <= w1_reg[ctl.sec];
                w1_reg[ctl.sec] <= w_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

>>> tb/butterworth_lowpass_4th_order_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// butterworth_lowpass_4th_order_unit_tb
// Self-checking bench for the two-section fourth-order low-pass unit.
// ---------------------------------------------------------------------------
// A bit-exact fixed-point model of the two cascaded biquads runs alongside the
// unit. It predicts one output word per accepted input word. Directed tests
// cover pass-through, a designed filter, and saturation corners. Many random
// register settings follow with random sample streams. Both handshake sides
// idle at random, the output side holds off long enough to back up the input,
// and the input side pauses until the unit has drained.
// ---------------------------------------------------------------------------
module butterworth_lowpass_4th_order_unit_tb;
    import bwlp_pkg::*;

    localparam int  COEF_FRAC   = COEF_WIDTH_DEF - COEF_INT_BITS;
    localparam int  STATE_FRAC  = STATE_WIDTH_DEF / 2;
    localparam longint W_ROUND  = longint'(1) <<< (COEF_FRAC - 1);
    localparam longint OUT_ROUND = longint'(1) <<< (STATE_FRAC - 1);
    localparam int  SETTLE      = 20;
    localparam int  MAX_IDLE    = 18;
    localparam int  LONG_HOLD   = 300;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{
        REG_ENABLE, REG_S1_GAIN, REG_S1_FB1, REG_S1_FB2,
        REG_S2_GAIN, REG_S2_FB1, REG_S2_FB2
    };

    localparam logic signed [COEF_WIDTH_DEF-1:0] COEF_MAX = 24'sh7FFFFF;
    localparam logic signed [COEF_WIDTH_DEF-1:0] COEF_MIN = 24'sh800000;
    localparam logic signed [COEF_WIDTH_DEF-1:0] COEF_ONE = 24'sh100000;

    // Fourth-order design at 50 Hz for a 1 kHz sample rate.
    localparam logic signed [COEF_WIDTH_DEF-1:0] DESIGNED [6] = '{
        24'sd19965, -24'sd1551497, 24'sd582767,
        24'sd22951, -24'sd1783565, 24'sd826793
    };

    typedef enum int {
        COEFS_DESIGNED,
        COEFS_MILD,
        COEFS_WILD,
        COEFS_CORNER
    } coef_profile_t;

    typedef enum int {
        SAMPLES_FULL,
        SAMPLES_SMALL,
        SAMPLES_STEPS
    } sample_profile_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bwlp_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) din_ch ();
    bwlp_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) dout_ch ();
    bwlp_cfg_if #(.IDX_WIDTH(CFG_IDX_W), .DATA_WIDTH(COEF_WIDTH_DEF)) cfg_ch ();

    butterworth_lowpass_4th_order_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch),
        .cfg   (cfg_ch)
    );

    logic                               filt_en = 1'b0;
    logic signed [COEF_WIDTH_DEF-1:0]   coef_reg [6] = '{default: '0};
    logic signed [STATE_WIDTH_DEF-1:0]  w1_q [2] = '{default: '0};
    logic signed [STATE_WIDTH_DEF-1:0]  w2_q [2] = '{default: '0};

    logic signed [SAMPLE_WIDTH_DEF-1:0] sample_out_q [$];

    int in_gap_max     = MAX_IDLE;
    int out_stall_max  = MAX_IDLE;
    int hold_request   = 0;
    int bad_words      = 0;
    int words_checked  = 0;
    int filtered_words = 0;
    int passed_words   = 0;
    int settings_used  = 0;

    always #6 clk = ~clk;

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint biquad(input longint src, input int sec);
        longint acc;
        longint w;
        longint y;
        acc = longint'(coef_reg[3*sec]) * src
            - longint'(coef_reg[3*sec+1]) * longint'(w1_q[sec])
            - longint'(coef_reg[3*sec+2]) * longint'(w2_q[sec]);
        w = clamp((acc + W_ROUND) >>> COEF_FRAC, STATE_WIDTH_DEF);
        y = clamp(w + 2 * longint'(w1_q[sec]) + longint'(w2_q[sec]), STATE_WIDTH_DEF);
        w2_q[sec] = w1_q[sec];
        w1_q[sec] = w[STATE_WIDTH_DEF-1:0];
        return y;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] filter_sample(
        input logic signed [SAMPLE_WIDTH_DEF-1:0] x
    );
        longint y1;
        longint y2;
        longint r;
        if (!filt_en)
        begin
            passed_words++;
            return x;
        end
        y1 = biquad(longint'(x) <<< STATE_FRAC, 0);
        y2 = biquad(y1, 1);
        r  = clamp((y2 + OUT_ROUND) >>> STATE_FRAC, SAMPLE_WIDTH_DEF);
        filtered_words++;
        return r[SAMPLE_WIDTH_DEF-1:0];
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] s);
        int gap;
        gap = $urandom_range(in_gap_max, 0);
        if (gap > 0)
        begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid     <= 1'b1;
        din_ch.sample_in <= s;
        @(posedge clk);
        while (!din_ch.ready)
            @(posedge clk);
        sample_out_q.push_back(filter_sample(s));
    endtask

    task automatic wait_idle();
        din_ch.valid <= 1'b0;
        while (sample_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_WIDTH_DEF-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_ENABLE)
            filt_en = value[0];
        else if (idx <= REG_S2_FB2)
            coef_reg[idx - REG_S1_GAIN] = value;
    endtask

    task automatic load_config(input logic en,
                               input logic signed [COEF_WIDTH_DEF-1:0] c [6]);
        logic [CFG_IDX_W-1:0]      idx;
        logic [COEF_WIDTH_DEF-1:0] value;
        int start;
        int unused_at;
        start     = $urandom_range(6, 0);
        unused_at = $urandom_range(6, 0);
        for (int k = 0; k < 7; k++)
        begin
            if (k == unused_at)
                write_reg(REG_UNUSED, COEF_WIDTH_DEF'($urandom()));
            idx = REG_ORDER[(start + k) % 7];
            if (idx == REG_ENABLE)
            begin
                value    = COEF_WIDTH_DEF'($urandom());
                value[0] = en;
            end
            else
                value = c[idx - REG_S1_GAIN];
            write_reg(idx, value);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_bypass_at_reset();
        in_gap_max    = MAX_IDLE;
        out_stall_max = MAX_IDLE;
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
    endtask

    task automatic test_designed_filter();
        wait_idle();
        load_config(1'b1, DESIGNED);
        repeat (4) send_sample(16'sd32767);
        repeat (3) send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
    endtask

    task automatic test_saturation();
        logic signed [COEF_WIDTH_DEF-1:0] c [6];
        wait_idle();
        c = '{COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN};
        load_config(1'b1, c);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        wait_idle();
        c = '{COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN};
        load_config(1'b1, c);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(16'sd1);
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        coef_profile_t                    cprof;
        sample_profile_t                  sprof;
        logic signed [COEF_WIDTH_DEF-1:0] c [6];
        logic signed [SAMPLE_WIDTH_DEF-1:0] s;
        logic en;
        for (int p = 0; p < phases; p++)
        begin
            cprof = coef_profile_t'($urandom_range(3, 0));
            for (int j = 0; j < 6; j++)
            begin
                case (cprof)
                    COEFS_DESIGNED:
                        c[j] = DESIGNED[j] + COEF_WIDTH_DEF'(int'($urandom_range(128, 0)) - 64);
                    COEFS_MILD:
                        c[j] = COEF_WIDTH_DEF'(int'($urandom_range(2097152, 0)) - 1048576);
                    COEFS_WILD:
                        c[j] = COEF_WIDTH_DEF'($urandom());
                    default:
                    begin
                        case ($urandom_range(4, 0))
                            0:       c[j] = COEF_MAX;
                            1:       c[j] = COEF_MIN;
                            2:       c[j] = COEF_ONE;
                            3:       c[j] = -COEF_ONE;
                            default: c[j] = '0;
                        endcase
                    end
                endcase
            end
            en = ($urandom_range(4, 0) != 0);
            wait_idle();
            load_config(en, c);
            case ($urandom_range(2, 0))
                0:       in_gap_max = 0;
                1:       in_gap_max = 4;
                default: in_gap_max = MAX_IDLE;
            endcase
            case ($urandom_range(2, 0))
                0:       out_stall_max = 0;
                1:       out_stall_max = 4;
                default: out_stall_max = MAX_IDLE;
            endcase
            sprof = sample_profile_t'($urandom_range(2, 0));
            s = '0;
            for (int i = 0; i < per_phase; i++)
            begin
                case (sprof)
                    SAMPLES_FULL:
                        s = SAMPLE_WIDTH_DEF'($urandom());
                    SAMPLES_SMALL:
                        s = SAMPLE_WIDTH_DEF'(int'($urandom_range(600, 0)) - 300);
                    default:
                    begin
                        if ($urandom_range(15, 0) == 0)
                        begin
                            case ($urandom_range(2, 0))
                                0:       s = 16'sh7FFF;
                                1:       s = 16'sh8000;
                                default: s = SAMPLE_WIDTH_DEF'($urandom());
                            endcase
                        end
                    end
                endcase
                send_sample(s);
            end
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        load_config(1'b1, DESIGNED);
        in_gap_max    = 0;
        out_stall_max = MAX_IDLE;
        hold_request  = LONG_HOLD;
        repeat (20) send_sample(SAMPLE_WIDTH_DEF'($urandom()));
    endtask

    task automatic test_drain_pause();
        wait_idle();
        in_gap_max    = MAX_IDLE;
        out_stall_max = MAX_IDLE;
        repeat (6)
        begin
            repeat (6) send_sample(SAMPLE_WIDTH_DEF'($urandom()));
            wait_idle();
        end
    endtask

    initial
    begin : out_sink
        int stall;
        int hold;
        logic signed [SAMPLE_WIDTH_DEF-1:0] want;
        dout_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall        = $urandom_range(out_stall_max, 0);
            hold         = hold_request;
            hold_request = 0;
            if (stall + hold > 0)
            begin
                dout_ch.ready <= 1'b0;
                repeat (stall + hold) @(posedge clk);
            end
            dout_ch.ready <= 1'b1;
            @(posedge clk);
            while (!dout_ch.valid)
                @(posedge clk);
            words_checked++;
            if (sample_out_q.size() == 0)
            begin
                $error("sample_out: no word expected, actual %0d", dout_ch.sample_out);
                bad_words++;
            end
            else
            begin
                want = sample_out_q.pop_front();
                if (dout_ch.sample_out !== want)
                begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           want, dout_ch.sample_out);
                    bad_words++;
                end
            end
        end
    end

    initial
    begin
        din_ch.valid     <= 1'b0;
        din_ch.sample_in <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_bypass_at_reset();
        test_designed_filter();
        test_saturation();
        test_random_settings(19, 100);
        test_backpressure();
        test_drain_pause();
        wait_idle();

        $display("Checked %0d output words: %0d filtered, %0d passed through.",
                 words_checked, filtered_words, passed_words);
        $display("Used %0d register settings, with back-pressure and drain pauses.",
                 settings_used);
        if (bad_words == 0 && sample_out_q.size() == 0)
            $display("butterworth_lowpass_4th_order_unit test passed");
        else
            $display("butterworth_lowpass_4th_order_unit test failed");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("butterworth_lowpass_4th_order_unit test failed");
        $finish;
    end

endmodule
